FILE: sv/pfa_pkg.sv
// -----------------------------------------------------------------------------
// Prime field ALU package
// Shared types, operation codes and word layout for the prime field ALU.
// -----------------------------------------------------------------------------
package pfa_pkg;

   // Width of the external operand, result and modulus fields.
   localparam int FIELD_W     = 32;
   localparam int OP_W        = 3;

   // Request word layout: op, operand_a, operand_b from the lowest bit up.
   localparam int REQ_OP_LSB  = 0;
   localparam int REQ_A_LSB   = OP_W;
   localparam int REQ_B_LSB   = OP_W + FIELD_W;
   localparam int REQ_TDATA_W = 72;

   // Response word layout: result, no_inverse from the lowest bit up.
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - FIELD_W - 1;

   // Operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4
   } pfa_op_type;

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_EUC_TEST,
      ST_EUC_WAIT,
      ST_EUC_FIX,
      ST_MUL,
      ST_FINISH
   } pfa_state_type;

endpackage

FILE: sv/pfa_divider.sv
// -----------------------------------------------------------------------------
// Prime field ALU bit-serial divider
// Restoring division, one quotient bit per cycle from the top bit down. The
// quotient bits also drive a Horner accumulator that forms quotient times a
// signed multiplier, which the extended Euclid update needs.
// -----------------------------------------------------------------------------
module pfa_divider #(
   parameter int W = 32,
   parameter int S = W + 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [W-1:0]        dividend,
   input  logic [W-1:0]        divisor,
   input  logic signed [S-1:0] multiplier,
   output logic                done,
   output logic [W-1:0]        remainder,
   output logic signed [S-1:0] product
);

   localparam int CW = $clog2(W);

   logic                busy_ff, busy_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [W-1:0]        num_ff, num_in;
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        den_ff, den_in;
   logic signed [S-1:0] mulv_ff, mulv_in;
   logic signed [S-1:0] prod_ff, prod_in;

   logic [W:0]          trial;
   logic                take;
   logic [W-1:0]        rem_step;
   logic signed [S-1:0] prod_step;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial     = {rem_ff, num_ff[W-1]};
      take      = (trial >= {1'b0, den_ff});
      rem_step  = take ? W'(trial - {1'b0, den_ff}) : W'(trial);
      prod_step = (prod_ff <<< 1) + (take ? mulv_ff : '0);
   end

   assign done      = busy_ff && (cnt_ff == '0);
   assign remainder = rem_step;
   assign product   = prod_step;

   // Load on start, otherwise step while busy.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      mulv_in = mulv_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W - 1);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         mulv_in = multiplier;
         prod_in = '0;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = rem_step;
         prod_in = prod_step;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      mulv_ff <= mulv_in;
      prod_ff <= prod_in;
   end

endmodule

FILE: sv/pfa_modmul.sv
// -----------------------------------------------------------------------------
// Prime field ALU bit-serial modular multiplier
// Double-and-add from the top multiplier bit down, with each step reduced
// modulo p. Each bit is a doubling followed by a conditional add.
// -----------------------------------------------------------------------------
module pfa_modmul #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] mcand,
   input  logic [W-1:0] mplier,
   input  logic [W-1:0] modulus,
   output logic         done,
   output logic [W-1:0] product
);

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  mcand_ff, mcand_in;
   logic [W-1:0]  mplier_ff, mplier_in;
   logic [W-1:0]  mod_ff, mod_in;

   logic [W-1:0]  addend;
   logic [W:0]    sum;
   logic [W-1:0]  acc_step;

   // Doubling in phase zero, conditional add of the multiplicand in phase one.
   always_comb begin
      if (phase_ff) begin
         addend = mplier_ff[W-1] ? mcand_ff : '0;
      end else begin
         addend = acc_ff;
      end
      sum      = {1'b0, acc_ff} + {1'b0, addend};
      acc_step = (sum >= {1'b0, mod_ff}) ? W'(sum - {1'b0, mod_ff}) : W'(sum);
   end

   assign done    = busy_ff && phase_ff && (cnt_ff == '0);
   assign product = acc_step;

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      mod_in    = mod_ff;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         cnt_in    = CW'(W - 1);
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         mod_in    = modulus;
      end else if (busy_ff) begin
         acc_in   = acc_step;
         phase_in = !phase_ff;
         if (phase_ff) begin
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      mod_ff    <= mod_in;
   end

endmodule

FILE: sv/prime_field_alu_core.sv
// -----------------------------------------------------------------------------
// Prime field ALU core
// Add, subtract, multiply, divide and compare modulo a programmable modulus,
// built from a bit-serial divider and a bit-serial modular multiplier.
// -----------------------------------------------------------------------------
//
//   Channel  Direction  Word contents (lowest bit first)
//   req_     in         op[2:0], operand_a[31:0], operand_b[31:0], zero pad
//   rsp_     out        result[31:0], no_inverse, zero pad
//   csr_     in         modulus[31:0], written when csr_wen is high
//
// Both operands are first reduced by the serial divider, one after the other.
// Add, subtract and compare then finish directly; multiply adds a pass through
// the double-and-add unit. Divide runs extended Euclid, one full division of
// the divider per quotient step, then one multiply.
// With a modulus below two every operation skips the units and returns zero,
// or one for compare. Reset is synchronous; the modulus resets to two. One word
// is in work at a time; a result held on a stalled rsp_ side stalls the next one at its end.
// -----------------------------------------------------------------------------
module prime_field_alu_core #(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // op[2:0], operand_a[34:3], operand_b[66:35]
   input  logic [pfa_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // result[31:0], no_inverse[32]
   output logic [pfa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_wen,
   input  logic [pfa_pkg::FIELD_W-1:0]    csr_wdata
);

   localparam int W = WIDTH;
   localparam int S = WIDTH + 2;

   pfa_pkg::pfa_state_type state_ff, state_in;

   logic [W-1:0]        mod_ff;
   logic [W-1:0]        a_ff, a_in;
   logic [W-1:0]        b_ff, b_in;
   pfa_pkg::pfa_op_type op_ff, op_in;
   logic [W-1:0]        r0_ff, r0_in;
   logic [W-1:0]        r1_ff, r1_in;
   logic signed [S-1:0] s0_ff, s0_in;
   logic signed [S-1:0] s1_ff, s1_in;
   logic [W-1:0]        res_ff, res_in;
   logic                noinv_ff, noinv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::FIELD_W-1:0] rsp_res_ff, rsp_res_in;
   logic                rsp_noinv_ff, rsp_noinv_in;

   logic                accept;
   logic                small_mod;
   logic [W-1:0]        req_a, req_b;
   pfa_pkg::pfa_op_type req_op;

   logic                div_start, div_done;
   logic [W-1:0]        div_dividend, div_divisor, div_rem;
   logic signed [S-1:0] div_mulv, div_prod;
   logic                mul_start, mul_done;
   logic [W-1:0]        mul_a, mul_b, mul_prod;

   logic [W:0]          add_sum;
   logic [W-1:0]        add_res, sub_res, inv_x;
   logic signed [S-1:0] s0_fix;
   logic                out_free;

   // Request word fields, masked or extended to the internal width.
   assign req_op    = pfa_pkg::pfa_op_type'(req_tdata[pfa_pkg::REQ_OP_LSB +: pfa_pkg::OP_W]);
   assign req_a     = W'(req_tdata[pfa_pkg::REQ_A_LSB +: pfa_pkg::FIELD_W]);
   assign req_b     = W'(req_tdata[pfa_pkg::REQ_B_LSB +: pfa_pkg::FIELD_W]);
   assign accept    = req_tvalid && req_tready;
   assign small_mod = (mod_ff < W'(2));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Combinational field add and subtract on reduced operands.
   always_comb begin
      add_sum = {1'b0, a_ff} + {1'b0, b_ff};
      add_res = (add_sum >= {1'b0, mod_ff}) ? W'(add_sum - {1'b0, mod_ff}) : W'(add_sum);
      sub_res = a_ff - b_ff + ((a_ff < b_ff) ? mod_ff : '0);
   end

   // Bring the Euclid coefficient into the range [0, p).
   always_comb begin
      s0_fix = s0_ff;
      if (s0_ff < 0) begin
         s0_fix = s0_ff + $signed({2'b00, mod_ff});
      end
      inv_x = W'(s0_fix);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = small_mod ? pfa_pkg::ST_FINISH : pfa_pkg::ST_RED_A;
            end
         end
         pfa_pkg::ST_RED_A: begin
            if (div_done) begin
               state_in = pfa_pkg::ST_RED_B;
            end
         end
         pfa_pkg::ST_RED_B: begin
            if (div_done) begin
               state_in = pfa_pkg::ST_DISPATCH;
            end
         end
         pfa_pkg::ST_DISPATCH: begin
            case (op_ff)
               pfa_pkg::OP_MUL: state_in = pfa_pkg::ST_MUL;
               pfa_pkg::OP_DIV: begin
                  state_in = (b_ff == '0) ? pfa_pkg::ST_FINISH : pfa_pkg::ST_EUC_TEST;
               end
               default:         state_in = pfa_pkg::ST_FINISH;
            endcase
         end
         pfa_pkg::ST_EUC_TEST: begin
            state_in = (r1_ff == '0) ? pfa_pkg::ST_EUC_FIX : pfa_pkg::ST_EUC_WAIT;
         end
         pfa_pkg::ST_EUC_WAIT: begin
            if (div_done) begin
               state_in = pfa_pkg::ST_EUC_TEST;
            end
         end
         pfa_pkg::ST_EUC_FIX: state_in = pfa_pkg::ST_MUL;
         pfa_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = pfa_pkg::ST_FINISH;
            end
         end
         pfa_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // Unit launches and handshake outputs.
   always_comb begin
      req_tready   = (state_ff == pfa_pkg::ST_IDLE);
      div_start    = 1'b0;
      div_dividend = r0_ff;
      div_divisor  = r1_ff;
      div_mulv     = s1_ff;
      mul_start    = 1'b0;
      mul_a        = a_ff;
      mul_b        = b_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            div_start    = accept && !small_mod;
            div_dividend = req_a;
            div_divisor  = mod_ff;
            div_mulv     = '0;
         end
         pfa_pkg::ST_RED_A: begin
            div_start    = div_done;
            div_dividend = b_ff;
            div_divisor  = mod_ff;
            div_mulv     = '0;
         end
         pfa_pkg::ST_DISPATCH: begin
            mul_start = (op_ff == pfa_pkg::OP_MUL);
         end
         pfa_pkg::ST_EUC_TEST: begin
            div_start = (r1_ff != '0);
         end
         pfa_pkg::ST_EUC_FIX: begin
            mul_start = 1'b1;
            mul_b     = inv_x;
         end
         default: begin
         end
      endcase
   end

   // Operand, Euclid and result registers.
   always_comb begin
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      res_in   = res_ff;
      noinv_in = noinv_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               b_in     = req_b;
               noinv_in = 1'b0;
               res_in   = (small_mod && req_op == pfa_pkg::OP_EQ) ? W'(1) : '0;
            end
         end
         pfa_pkg::ST_RED_A: begin
            if (div_done) begin
               a_in = div_rem;
            end
         end
         pfa_pkg::ST_RED_B: begin
            if (div_done) begin
               b_in = div_rem;
            end
         end
         pfa_pkg::ST_DISPATCH: begin
            r0_in = b_ff;
            r1_in = mod_ff;
            s0_in = S'(1);
            s1_in = '0;
            case (op_ff)
               pfa_pkg::OP_ADD: res_in = add_res;
               pfa_pkg::OP_SUB: res_in = sub_res;
               pfa_pkg::OP_EQ:  res_in = (a_ff == b_ff) ? W'(1) : '0;
               pfa_pkg::OP_DIV: begin
                  res_in   = '0;
                  noinv_in = (b_ff == '0);
               end
               default:         res_in = '0;
            endcase
         end
         pfa_pkg::ST_EUC_WAIT: begin
            if (div_done) begin
               r0_in = r1_ff;
               r1_in = div_rem;
               s0_in = s1_ff;
               s1_in = s0_ff - div_prod;
            end
         end
         pfa_pkg::ST_EUC_FIX: begin
            noinv_in = (r0_ff != W'(1));
         end
         pfa_pkg::ST_MUL: begin
            if (mul_done) begin
               res_in = mul_prod;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded at the end of an operation, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_noinv_in = rsp_noinv_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == pfa_pkg::ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = pfa_pkg::FIELD_W'(res_ff);
         rsp_noinv_in = noinv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pfa_pkg::RSP_PAD_W{1'b0}}, rsp_noinv_ff, rsp_res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            mod_ff <= W'(csr_wdata);
         end
      end
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      res_ff       <= res_in;
      noinv_ff     <= noinv_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_noinv_ff <= rsp_noinv_in;
   end

   // Shared serial divider: operand reduction and Euclid quotient steps.
   pfa_divider #(
      .W (W),
      .S (S)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .multiplier (div_mulv),
      .done       (div_done),
      .remainder  (div_rem),
      .product    (div_prod)
   );

   // Serial modular multiplier: multiply and the final step of divide.
   pfa_modmul #(
      .W (W)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .modulus (mod_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

endmodule
